### rtl/etu_pkg.sv
// ----------------------------------------------------------------------------
// etu_pkg: shared types and constants of the elevation tile upsampler
// payload structs, register indexes, pixel kinds and tap weights
// ----------------------------------------------------------------------------
package etu_pkg;

    localparam int VALUE_BITS      = 32;
    localparam int COORD_BITS      = 8;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 8;
    localparam int WEIGHT_BITS     = 10;
    localparam int WEIGHT_SHIFT    = 8;
    localparam int MIN_TILE_WIDTH  = 7;
    localparam int TILE_WIDTH_RST  = 133;
    localparam int BORDER_SAMPLES  = 5;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_LEVEL        = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_ODD            = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_ODD            = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TILE_WIDTH       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RESIDUAL_PRESENT = 3'd4;

    // input function codes
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    // pixel kinds by column/row parity
    localparam logic [1:0] PIX_COPY = 2'd0;
    localparam logic [1:0] PIX_HORZ = 2'd1;
    localparam logic [1:0] PIX_VERT = 2'd2;
    localparam logic [1:0] PIX_DIAG = 2'd3;

    typedef struct packed {
        logic                         func;
        logic signed [VALUE_BITS-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] height;
        logic [COORD_BITS-1:0]        column;
        logic [COORD_BITS-1:0]        row;
        logic                         last;
    } result_t;

    // one axis of the kernel, scaled by 16; an inactive axis passes the centre tap
    function automatic int axis_weight(input logic active, input logic [1:0] idx);
        int w;
        w = 0;
        if (active)
        begin
            case (idx)
                2'd0:    w = -1;
                2'd1:    w = 9;
                2'd2:    w = 9;
                default: w = -1;
            endcase
        end
        else
        begin
            w = (idx == 2'd1) ? 16 : 0;
        end
        return w;
    endfunction

    // weight of tap (d, e), scaled by 256 for every pixel kind
    function automatic logic signed [WEIGHT_BITS-1:0] tap_weight(
        input logic [1:0] kind,
        input logic [1:0] d,
        input logic [1:0] e
    );
        int wx;
        int wy;
        wx = axis_weight(kind[0], d);
        wy = axis_weight(kind[1], e);
        return WEIGHT_BITS'(wx * wy);
    endfunction

endpackage

### rtl/elevation_tile_upsampler.sv
// ----------------------------------------------------------------------------
// elevation_tile_upsampler: 2x cubic subdivision of a parent height tile
// loads a parent tile into a two-port store, then interpolates child pixels
// ----------------------------------------------------------------------------
// load transaction: next item taken in the following cycle
// compute transaction: issue, drain and final steps, with one parent read per tap
//   on the single read port (1 copy, 4 one-axis, 16 both-axis)
// top level reads nothing: straight to the final step; items stall until idle
// a full, stalled result register holds the next result back in its final step
// reset: control and counters cleared at once, parent store not cleared
// ----------------------------------------------------------------------------
module elevation_tile_upsampler #(
    parameter int MAX_TILE_WIDTH = 133,
    parameter int HEIGHT_BITS    = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  etu_pkg::item_t                      item,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output etu_pkg::result_t                    result,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [etu_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [etu_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    // store geometry
    localparam int DEPTH = MAX_TILE_WIDTH * MAX_TILE_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = etu_pkg::COORD_BITS;
    localparam int VW    = etu_pkg::VALUE_BITS;
    localparam int WW    = etu_pkg::WEIGHT_BITS;

    // widest usable tile width fits the 8-bit register
    localparam int W_MAX  = (MAX_TILE_WIDTH > 255) ? 255 : MAX_TILE_WIDTH;
    localparam int W_RST  = (etu_pkg::TILE_WIDTH_RST > W_MAX) ? W_MAX
                                                              : etu_pkg::TILE_WIDTH_RST;

    // accumulator: 16 taps, weight magnitudes sum to 400
    localparam int ACC_W  = VW + WW + 2;
    localparam int SUM_W  = ((ACC_W > HEIGHT_BITS) ? ACC_W : HEIGHT_BITS) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((65'sd1 <<< (HEIGHT_BITS - 1)) - 65'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    // configuration registers
    logic          top_level_reg;
    logic          x_odd_reg;
    logic          y_odd_reg;
    logic [CW-1:0] width_reg;         // effective, already clamped
    logic          residual_present_reg;

    // load and output position
    logic [CW-1:0] load_col_reg;
    logic [CW-1:0] load_row_reg;
    logic [AW-1:0] load_addr_reg;
    logic [CW-1:0] out_col_reg;
    logic [CW-1:0] out_row_reg;

    // per-pixel context
    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [1:0]            kind_reg;
    logic [3:0]            tap_reg;
    logic [3:0]            tap_last_reg;
    logic [CW:0]           bc_reg;
    logic [CW:0]           br_reg;
    logic signed [VW-1:0]  resid_reg;
    logic [CW-1:0]         pix_col_reg;
    logic [CW-1:0]         pix_row_reg;
    logic                  pix_last_reg;

    // read pipeline
    logic                  rd_valid_reg;
    logic [AW-1:0]         rd_addr_reg;
    logic signed [WW-1:0]  rd_wt_reg;
    logic                  mac_valid_reg;
    logic signed [VW-1:0]  mac_data_reg;
    logic signed [WW-1:0]  mac_wt_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // output register
    logic                  result_valid_reg;
    etu_pkg::result_t      result_reg;

    // parent store
    logic [VW-1:0] store_mem [DEPTH];

    logic load_take;
    logic comp_take;
    logic cfg_take;
    logic out_free;

    logic [CW-1:0]  w_m1;
    logic [CW-2:0]  half;
    logic [CW:0]    bc_new;
    logic [CW:0]    br_new;
    logic [1:0]     tap_d;
    logic [1:0]     tap_e;
    logic [CW+1:0]  c_raw;
    logic [CW+1:0]  r_raw;
    logic [CW-1:0]  c_clamp;
    logic [CW-1:0]  r_clamp;
    logic [2*CW-1:0] row_base;
    logic [AW-1:0]  tap_addr;

    logic signed [VW+WW-1:0]  product;
    logic signed [ACC_W-1:0]  z_shift;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sat;
    logic [CW-1:0]            cfg_width;

    assign cfg_ready    = 1'b1;
    assign cfg_take     = cfg_valid;
    assign item_stall   = (state_reg != S_IDLE);
    assign load_take    = item_valid && !item_stall && (item.func == etu_pkg::FUNC_LOAD);
    assign comp_take    = item_valid && !item_stall && (item.func == etu_pkg::FUNC_COMPUTE);
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // clamp of a written tile width
    always_comb
    begin
        if (cfg_data < CW'(etu_pkg::MIN_TILE_WIDTH))
        begin
            cfg_width = CW'(etu_pkg::MIN_TILE_WIDTH);
        end
        else if (cfg_data > CW'(W_MAX))
        begin
            cfg_width = CW'(W_MAX);
        end
        else
        begin
            cfg_width = cfg_data;
        end
    end

    // quadrant base in the parent tile
    assign w_m1   = width_reg - CW'(1);
    assign half   = (CW-1)'((width_reg - CW'(etu_pkg::BORDER_SAMPLES)) >> 1);
    assign bc_new = (CW+1)'(out_col_reg >> 1) + (CW+1)'(1)
                  + (x_odd_reg ? (CW+1)'(half) : '0);
    assign br_new = (CW+1)'(out_row_reg >> 1) + (CW+1)'(1)
                  + (y_odd_reg ? (CW+1)'(half) : '0);

    // tap offsets by pixel kind
    always_comb
    begin
        case (kind_reg)
            etu_pkg::PIX_HORZ:
            begin
                tap_d = tap_reg[1:0];
                tap_e = 2'd1;
            end
            etu_pkg::PIX_VERT:
            begin
                tap_d = 2'd1;
                tap_e = tap_reg[1:0];
            end
            etu_pkg::PIX_DIAG:
            begin
                tap_d = tap_reg[1:0];
                tap_e = tap_reg[3:2];
            end
            default:
            begin
                tap_d = 2'd1;
                tap_e = 2'd1;
            end
        endcase
    end

    // base is at least one, so the tap coordinate never goes negative
    assign c_raw   = (CW+2)'(bc_reg) + (CW+2)'(tap_d) - (CW+2)'(1);
    assign r_raw   = (CW+2)'(br_reg) + (CW+2)'(tap_e) - (CW+2)'(1);
    assign c_clamp = (c_raw > (CW+2)'(w_m1)) ? w_m1 : c_raw[CW-1:0];
    assign r_clamp = (r_raw > (CW+2)'(w_m1)) ? w_m1 : r_raw[CW-1:0];
    assign row_base = r_clamp * width_reg;
    assign tap_addr = AW'(row_base) + AW'(c_clamp);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (comp_take)
                begin
                    state_next = top_level_reg ? S_FINAL : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (tap_reg == tap_last_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !mac_valid_reg)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_level_reg        <= 1'b0;
            x_odd_reg            <= 1'b0;
            y_odd_reg            <= 1'b0;
            width_reg            <= CW'(W_RST);
            residual_present_reg <= 1'b1;
            load_col_reg         <= '0;
            load_row_reg         <= '0;
            load_addr_reg        <= '0;
            out_col_reg          <= '0;
            out_row_reg          <= '0;
        end
        else if (cfg_take)
        begin
            unique case (cfg_index)
                etu_pkg::REG_TOP_LEVEL:        top_level_reg        <= cfg_data[0];
                etu_pkg::REG_X_ODD:            x_odd_reg            <= cfg_data[0];
                etu_pkg::REG_Y_ODD:            y_odd_reg            <= cfg_data[0];
                etu_pkg::REG_RESIDUAL_PRESENT: residual_present_reg <= cfg_data[0];
                etu_pkg::REG_TILE_WIDTH:
                begin
                    width_reg     <= cfg_width;
                    load_col_reg  <= '0;
                    load_row_reg  <= '0;
                    load_addr_reg <= '0;
                    out_col_reg   <= '0;
                    out_row_reg   <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            if (load_take)
            begin
                if (load_col_reg == w_m1)
                begin
                    load_col_reg <= '0;
                    if (load_row_reg == w_m1)
                    begin
                        load_row_reg  <= '0;
                        load_addr_reg <= '0;
                    end
                    else
                    begin
                        load_row_reg  <= load_row_reg + CW'(1);
                        load_addr_reg <= load_addr_reg + AW'(1);
                    end
                end
                else
                begin
                    load_col_reg  <= load_col_reg + CW'(1);
                    load_addr_reg <= load_addr_reg + AW'(1);
                end
            end
            if (comp_take)
            begin
                if (out_col_reg >= w_m1)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= (out_row_reg >= w_m1) ? '0 : out_row_reg + CW'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

    // pixel context, captured when the compute transaction is taken
    always_ff @(posedge clk)
    begin
        if (comp_take)
        begin
            kind_reg     <= {out_row_reg[0], out_col_reg[0]};
            unique case ({out_row_reg[0], out_col_reg[0]}) inside
                etu_pkg::PIX_DIAG:                    tap_last_reg <= 4'd15;
                etu_pkg::PIX_HORZ, etu_pkg::PIX_VERT: tap_last_reg <= 4'd3;
                default:                              tap_last_reg <= 4'd0;
            endcase
            bc_reg       <= bc_new;
            br_reg       <= br_new;
            resid_reg    <= residual_present_reg ? item.value : '0;
            pix_col_reg  <= out_col_reg;
            pix_row_reg  <= out_row_reg;
            pix_last_reg <= (out_col_reg >= w_m1) && (out_row_reg >= w_m1);
        end
    end

    // tap counter, read issue and multiply-accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            mac_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            rd_valid_reg  <= (state_reg == S_ISSUE);
            mac_valid_reg <= rd_valid_reg;
            if (comp_take)
            begin
                tap_reg <= '0;
                acc_reg <= '0;
            end
            else
            begin
                if (state_reg == S_ISSUE)
                begin
                    tap_reg <= tap_reg + 4'd1;
                end
                if (mac_valid_reg)
                begin
                    acc_reg <= acc_reg + ACC_W'(product);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= tap_addr;
        rd_wt_reg   <= etu_pkg::tap_weight(kind_reg, tap_d, tap_e);
        mac_wt_reg  <= rd_wt_reg;
    end

    assign product = mac_data_reg * mac_wt_reg;

    // parent store: one write port for loads, one registered read port
    always_ff @(posedge clk)
    begin
        if (load_take)
        begin
            store_mem[load_addr_reg] <= item.value;
        end
        mac_data_reg <= signed'(store_mem[rd_addr_reg]);
    end

    // weights carry a factor of 256, removed by a floor shift
    assign z_shift = acc_reg >>> etu_pkg::WEIGHT_SHIFT;
    assign sum     = SUM_W'(z_shift) + SUM_W'(resid_reg);

    always_comb
    begin
        if (sum > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (sum < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = sum;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_FINAL) && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FINAL) && out_free)
        begin
            result_reg.height <= sat[VW-1:0];
            result_reg.column <= pix_col_reg;
            result_reg.row    <= pix_row_reg;
            result_reg.last   <= pix_last_reg;
        end
    end

endmodule
